// File: rtl/vdft_pkg.sv
package vdft_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int ENTRY_W       = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = ENTRY_W + 1;
    localparam int ID_W          = 10;
    localparam int IDX_W         = 16;
    localparam int KEY_W         = 4 * IDX_W;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_COUNTER_CLOCKWISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_NORMALS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_USE_TEXCOORDS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_USE_COLOURS       = 2'd3;

    typedef struct packed {
        logic             new_shape;
        logic             new_face;
        logic [IDX_W-1:0] pos_index;
        logic [IDX_W-1:0] normal_index;
        logic [IDX_W-1:0] texcoord_index;
        logic [IDX_W-1:0] colour_index;
    } in_t;

    typedef struct packed {
        logic            new_vertex;
        logic [ID_W-1:0] vertex_id;
        logic            triangle_valid;
        logic [ID_W-1:0] tri_first;
        logic [ID_W-1:0] tri_second;
        logic [ID_W-1:0] tri_third;
        logic            table_full;
    } out_t;

    typedef struct packed {
        logic counter_clockwise;
        logic use_normals;
        logic use_texcoords;
        logic use_colours;
    } cfg_t;

endpackage

// File: rtl/vdft_key_ram.sv
module vdft_key_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/vdft_cfg_regs.sv
module vdft_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [vdft_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                          cfg_data,
    output vdft_pkg::cfg_t                cfg
);

    import vdft_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_COUNTER_CLOCKWISE: cfg_next.counter_clockwise = cfg_data;
                REG_USE_NORMALS:       cfg_next.use_normals       = cfg_data;
                REG_USE_TEXCOORDS:     cfg_next.use_texcoords     = cfg_data;
                REG_USE_COLOURS:       cfg_next.use_colours       = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{counter_clockwise: 1'b1, use_normals: 1'b0,
                         use_texcoords: 1'b0, use_colours: 1'b0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/vertex_dedup_fan_triangulator.sv
// Vertex deduplication and fan triangulation.
// Input channel (in_valid/in_ready/in_data) takes one polygon corner per
// transaction; output channel (out_valid/out_ready/out_data) returns one
// result per corner, in order. cfg_we/cfg_index/cfg_data write the
// winding and attribute-enable registers. The corner key is compared
// against the stored keys in insertion order, one key memory read per
// cycle. The scan ends at the first stored key that matches on a hit and
// reads every stored key on a miss; the result is then loaded into the
// output register, and the input is ready again in the same cycle as the
// result appears in that register.
// One corner is in work at a time; a new corner is taken as soon as the
// previous result sits in the output register, even while it waits.
// When the receiver stalls, the result holds in the output register and
// the next corner waits in its final step until the register frees.
// Reset empties the table, clears the fan state and sets counter-clockwise
// winding with all optional attributes off; no clearing pass is needed.
module vertex_dedup_fan_triangulator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  vdft_pkg::in_t                  in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output vdft_pkg::out_t                 out_data,
    input  logic                           cfg_we,
    input  logic [vdft_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                           cfg_data
);

    import vdft_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    cfg_t cfg;

    logic [1:0]         state_reg, state_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic               pend_reg, pend_next;
    logic [ENTRY_W-1:0] pend_idx_reg, pend_idx_next;
    logic               found_reg, found_next;
    logic [ENTRY_W-1:0] hit_idx_reg, hit_idx_next;
    logic [ID_W-1:0]    anchor_reg, anchor_next;
    logic [ID_W-1:0]    prev_reg, prev_next;
    logic [1:0]         corner_reg, corner_next;
    logic               out_valid_reg, out_valid_next;
    out_t               out_reg, out_next;

    logic               ram_we;
    logic               ram_re;
    logic [KEY_W-1:0]   ram_rdata;
    logic               out_free;
    logic               is_full;
    logic [ID_W-1:0]    cur_id;

    vdft_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vdft_key_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (KEY_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ENTRY_W-1:0]),
        .wdata (key_reg),
        .re    (ram_re),
        .raddr (scan_reg[ENTRY_W-1:0]),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign is_full   = !found_reg && (count_reg == CNT_W'(TABLE_ENTRIES));
    assign cur_id    = found_reg ? ID_W'(hit_idx_reg) : ID_W'(count_reg);
    assign ram_re    = (state_reg == ST_SCAN) && (scan_reg < count_reg);
    assign ram_we    = (state_reg == ST_FINISH) && out_free && !found_reg && !is_full;

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        found_next     = found_reg;
        hit_idx_next   = hit_idx_reg;
        anchor_next    = anchor_reg;
        prev_next      = prev_reg;
        corner_next    = corner_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    key_next = {in_data.pos_index,
                                cfg.use_normals   ? in_data.normal_index   : IDX_W'(0),
                                cfg.use_texcoords ? in_data.texcoord_index : IDX_W'(0),
                                cfg.use_colours   ? in_data.colour_index   : IDX_W'(0)};
                    if (in_data.new_shape)
                    begin
                        count_next = '0;
                    end
                    if (in_data.new_shape || in_data.new_face)
                    begin
                        corner_next = 2'd0;
                    end
                    scan_next  = '0;
                    pend_next  = 1'b0;
                    found_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (pend_reg && (ram_rdata == key_reg))
                begin
                    found_next   = 1'b1;
                    hit_idx_next = pend_idx_reg;
                    pend_next    = 1'b0;
                    state_next   = ST_FINISH;
                end
                else if (scan_reg < count_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[ENTRY_W-1:0];
                    scan_next     = scan_reg + 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_next       = '0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (is_full)
                    begin
                        out_next.table_full = 1'b1;
                    end
                    else
                    begin
                        out_next.new_vertex = !found_reg;
                        out_next.vertex_id  = cur_id;
                        if (!found_reg)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        case (corner_reg)
                            2'd0:
                            begin
                                anchor_next = cur_id;
                                corner_next = 2'd1;
                            end
                            2'd1:
                            begin
                                prev_next   = cur_id;
                                corner_next = 2'd2;
                            end
                            default:
                            begin
                                out_next.triangle_valid = 1'b1;
                                out_next.tri_first      = anchor_reg;
                                out_next.tri_second     = cfg.counter_clockwise ? prev_reg : cur_id;
                                out_next.tri_third      = cfg.counter_clockwise ? cur_id : prev_reg;
                                prev_next               = cur_id;
                                corner_next             = 2'd2;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            anchor_reg    <= '0;
            prev_reg      <= '0;
            corner_reg    <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            anchor_reg    <= anchor_next;
            prev_reg      <= prev_next;
            corner_reg    <= corner_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        pend_idx_reg <= pend_idx_next;
        hit_idx_reg  <= hit_idx_next;
        out_reg      <= out_next;
    end

endmodule
